>>> src/htkf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the top-k frequency counter.
// Used by htkf_rank, histogram_top_k_frequency and the testbench; depends on nothing.
package htkf_pkg;

    // Defaults of the top-level parameters.
    localparam int KEY_COUNT_DEF  = 1024;
    localparam int MAX_TOP_DEF    = 16;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed field widths of the channels.
    localparam int KEY_W       = 10;
    localparam int FREQ_W      = 32;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 48;
    localparam int TOPCNT_W    = 5;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [TOPCNT_W-1:0] TOP_COUNT_RST = 5'd10;

    // Command carried in s_tuser.
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_TOP_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } htkf_state_t;

    // Control from the sequencer to the ranking list.
    typedef struct packed {
        logic start;    // a report begins: the list is emptied
        logic ins_vld;  // a scanned count is offered for insertion
    } htkf_rank_ctrl_t;

endpackage

>>> src/htkf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module htkf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/htkf_rank.sv
`timescale 1ns / 1ps
// Ranked list of the most frequent keys, built by insertion during a scan.
// Depends on htkf_pkg.
module htkf_rank import htkf_pkg::*; #(
    parameter int MAX_TOP    = MAX_TOP_DEF,
    parameter int ADDR_W     = 10,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int LIM_W      = $clog2(MAX_TOP + 1),
    parameter int IDX_W      = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  htkf_rank_ctrl_t       ctrl,
    input  logic [ADDR_W-1:0]     ins_key,
    input  logic [COUNT_BITS-1:0] ins_cnt,
    input  logic [LIM_W-1:0]      limit,
    input  logic [IDX_W-1:0]      rd_idx,
    output logic [ADDR_W-1:0]     rd_key,
    output logic [COUNT_BITS-1:0] rd_cnt,
    output logic [LIM_W-1:0]      kept
);

    logic [ADDR_W-1:0]     key_reg  [MAX_TOP];
    logic [ADDR_W-1:0]     key_next [MAX_TOP];
    logic [COUNT_BITS-1:0] cnt_reg  [MAX_TOP];
    logic [COUNT_BITS-1:0] cnt_next [MAX_TOP];
    logic [LIM_W-1:0]      kept_reg;
    logic [LIM_W-1:0]      kept_next;
    logic [MAX_TOP-1:0]    ge;
    logic [LIM_W-1:0]      lim_m1;
    logic                  ins;

    // The list is sorted by descending count, so the entries whose count is at
    // least the new one form a prefix; the new entry goes right after it.
    // Equal counts stay ahead, which keeps the lower key first.
    always_comb begin
        for (int i = 0; i < MAX_TOP; i++) begin
            ge[i] = (LIM_W'(i) < kept_reg) && (cnt_reg[i] >= ins_cnt);
        end
        lim_m1 = limit - LIM_W'(1);
        ins    = ctrl.ins_vld && (ins_cnt != '0)
                 && ((kept_reg < limit) || !ge[lim_m1[IDX_W-1:0]]);

        key_next = key_reg;
        cnt_next = cnt_reg;
        if (ins && !ge[0]) begin
            key_next[0] = ins_key;
            cnt_next[0] = ins_cnt;
        end
        for (int i = 1; i < MAX_TOP; i++) begin
            if (ins && !ge[i]) begin
                if (ge[i-1]) begin
                    key_next[i] = ins_key;
                    cnt_next[i] = ins_cnt;
                end else begin
                    key_next[i] = key_reg[i-1];
                    cnt_next[i] = cnt_reg[i-1];
                end
            end
        end

        if (ctrl.start) begin
            kept_next = '0;
        end else if (ins && (kept_reg < limit)) begin
            kept_next = kept_reg + LIM_W'(1);
        end else begin
            kept_next = kept_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg <= '0;
        end else begin
            kept_reg <= kept_next;
        end
    end

    assign rd_key = key_reg[rd_idx];
    assign rd_cnt = cnt_reg[rd_idx];
    assign kept   = kept_reg;

endmodule

>>> src/histogram_top_k_frequency.sv
`timescale 1ns / 1ps
// Exact frequency counter with a top-k report.
// Usage:
//   s_ channel: s_tuser selects the command (0 add, 1 report), s_tdata[9:0]
//   holds the key. An add counts one more occurrence of the key in a
//   histogram RAM; keys at or above KEY_COUNT are ignored and counts saturate.
//   Adds stream in at one item per cycle while s_tready is high, through a
//   read-modify-write on the RAM with forwarding of the previous write.
//   A report scans the RAM in key order, one entry per cycle, and ranks
//   the keys in a list of MAX_TOP cells. Then up to top_count results (at
//   most MAX_TOP, at least one) leave on the m_ channel, one per cycle while
//   m_tready is high, the last with m_tlast set. An empty histogram gives
//   one result with m_tuser low.
//   Counts are kept after a report.
//   While a report is scanned or emitted, s_tready is low. A stalled result
//   waits in the output register; nothing is lost.
//   After reset the block clears the RAM with s_tready low. The APB
//   register top_count (address 0, reset 10) may be written at any time the
//   block is idle.
// Depends on htkf_pkg, htkf_ram and htkf_rank.
module histogram_top_k_frequency import htkf_pkg::*; #(
    parameter int KEY_COUNT  = KEY_COUNT_DEF,
    parameter int MAX_TOP    = MAX_TOP_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] key, [15:10] zero
    input  logic [0:0]            s_tuser,   // [0] cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] top_key, [41:10] frequency, rest zero
    output logic [0:0]            m_tuser,   // [0] found
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W = $clog2(KEY_COUNT);
    localparam int CNT_W  = $clog2(KEY_COUNT + 1);
    localparam int LIM_W  = $clog2(MAX_TOP + 1);
    localparam int IDX_W  = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;

    htkf_state_t           state_reg, state_next;
    logic [CNT_W-1:0]      addr_reg, addr_next;
    logic [TOPCNT_W-1:0]   top_count_reg;

    logic                  add_vld_reg;
    logic [ADDR_W-1:0]     add_addr_reg;
    logic                  wr_vld_reg;
    logic [ADDR_W-1:0]     wr_addr_reg;
    logic [COUNT_BITS-1:0] wr_cnt_reg;
    logic                  sc_vld_reg;
    logic [ADDR_W-1:0]     sc_key_reg;
    logic [LIM_W-1:0]      emit_idx_reg, emit_idx_next;

    logic                  m_tvalid_reg;
    logic [KEY_W-1:0]      key_out_reg;
    logic [FREQ_W-1:0]     freq_out_reg;
    logic                  found_out_reg;
    logic                  last_out_reg;

    logic                  s_fire, add_fire, rep_fire, key_ok;
    logic [ADDR_W-1:0]     s_addr;
    logic                  scan_issue, clear_wr, out_free, emit_go, emit_last;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, add_old, add_new;
    logic [LIM_W-1:0]      limit, kept;
    logic [ADDR_W-1:0]     rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [63:0]           rd_cnt_ext;
    logic [FREQ_W-1:0]     rd_freq;
    logic                  apb_wr;
    htkf_rank_ctrl_t       rank_ctrl;

    // Input decode.
    assign s_fire   = s_tvalid && s_tready;
    assign key_ok   = 32'(s_tdata[KEY_W-1:0]) < 32'(KEY_COUNT);
    assign s_addr   = ADDR_W'(s_tdata[KEY_W-1:0]);
    assign add_fire = s_fire && (s_tuser[0] == CMD_ADD) && key_ok;
    assign rep_fire = s_fire && (s_tuser[0] == CMD_REPORT);

    // Register interface.
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_TOP_COUNT) ? APB_DATA_W'(top_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_count_reg <= TOP_COUNT_RST;
        end else if (apb_wr && (paddr[2] == REG_TOP_COUNT)) begin
            top_count_reg <= pwdata[TOPCNT_W-1:0];
        end
    end

    always_comb begin
        if (top_count_reg == '0) begin
            limit = LIM_W'(1);
        end else if (8'(top_count_reg) > 8'(MAX_TOP)) begin
            limit = LIM_W'(MAX_TOP);
        end else begin
            limit = LIM_W'(top_count_reg);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (addr_reg == CNT_W'(KEY_COUNT - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (rep_fire) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if ((addr_reg == CNT_W'(KEY_COUNT)) && !sc_vld_reg) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_go && emit_last) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready   = 1'b0;
        scan_issue = 1'b0;
        clear_wr   = 1'b0;
        emit_go    = 1'b0;
        ram_raddr  = s_addr;
        unique case (state_reg)
            ST_CLEAR: clear_wr = 1'b1;
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN: begin
                scan_issue = (addr_reg != CNT_W'(KEY_COUNT));
                ram_raddr  = addr_reg[ADDR_W-1:0];
            end
            ST_EMIT:  emit_go = out_free;
            default: ;
        endcase
    end

    // Sweep counter shared by the clearing pass and the scan.
    always_comb begin
        addr_next = addr_reg;
        if (clear_wr) begin
            addr_next = (addr_reg == CNT_W'(KEY_COUNT - 1)) ? '0 : addr_reg + CNT_W'(1);
        end else if (state_reg == ST_IDLE) begin
            addr_next = '0;
        end else if (scan_issue) begin
            addr_next = addr_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    // Add path: the RAM read is issued on acceptance, the increment and the
    // write follow in the next cycle. The write of the cycle before is not yet
    // in the read data, so a back-to-back add of the same key takes it from
    // the last-write register.
    assign add_old = (wr_vld_reg && (wr_addr_reg == add_addr_reg)) ? wr_cnt_reg : ram_rdata;
    assign add_new = (add_old == '1) ? add_old : add_old + COUNT_BITS'(1);

    assign ram_we    = clear_wr || add_vld_reg;
    assign ram_waddr = clear_wr ? addr_reg[ADDR_W-1:0] : add_addr_reg;
    assign ram_wdata = clear_wr ? '0 : add_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
            sc_vld_reg  <= 1'b0;
        end else begin
            add_vld_reg <= add_fire;
            wr_vld_reg  <= add_vld_reg;
            sc_vld_reg  <= scan_issue;
        end
    end

    always_ff @(posedge aclk) begin
        add_addr_reg <= s_addr;
        wr_addr_reg  <= add_addr_reg;
        wr_cnt_reg   <= add_new;
        sc_key_reg   <= addr_reg[ADDR_W-1:0];
    end

    htkf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (KEY_COUNT)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rank_ctrl.start   = rep_fire;
    assign rank_ctrl.ins_vld = sc_vld_reg;

    htkf_rank #(
        .MAX_TOP    (MAX_TOP),
        .ADDR_W     (ADDR_W),
        .COUNT_BITS (COUNT_BITS),
        .LIM_W      (LIM_W),
        .IDX_W      (IDX_W)
    ) u_rank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rank_ctrl),
        .ins_key (sc_key_reg),
        .ins_cnt (ram_rdata),
        .limit   (limit),
        .rd_idx  (emit_idx_reg[IDX_W-1:0]),
        .rd_key  (rd_key),
        .rd_cnt  (rd_cnt),
        .kept    (kept)
    );

    // Result path.
    assign out_free   = !m_tvalid_reg || m_tready;
    assign emit_last  = (kept == '0) || ((emit_idx_reg + LIM_W'(1)) == kept);
    assign rd_cnt_ext = 64'(rd_cnt);
    assign rd_freq    = (rd_cnt_ext[63:FREQ_W] != '0) ? '1 : rd_cnt_ext[FREQ_W-1:0];

    always_comb begin
        emit_idx_next = emit_idx_reg;
        if (rep_fire) begin
            emit_idx_next = '0;
        end else if (emit_go && !emit_last) begin
            emit_idx_next = emit_idx_reg + LIM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            emit_idx_reg <= emit_idx_next;
            if (emit_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            found_out_reg <= (kept != '0);
            last_out_reg  <= emit_last;
            key_out_reg   <= (kept != '0) ? KEY_W'(rd_key) : '0;
            freq_out_reg  <= (kept != '0) ? rd_freq : '0;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {(M_TDATA_W - FREQ_W - KEY_W)'(0), freq_out_reg, key_out_reg};
    assign m_tuser[0] = found_out_reg;
    assign m_tlast    = last_out_reg;

`ifndef SYNTH
    // Histogram updates never overlap the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        add_vld_reg |-> (state_reg != ST_CLEAR))
        else $error("add write during clearing pass");

    // The forwarding register always holds the write of the cycle before.
    assert property (@(posedge aclk) disable iff (!aresetn)
        add_vld_reg |=> (wr_vld_reg && (wr_addr_reg == $past(add_addr_reg))))
        else $error("forwarding register lost an add write");

    // Once a scan is under way, no add write can still be pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) && $past(state_reg == ST_SCAN)) |-> !add_vld_reg)
        else $error("add write overlaps scan reads");

    // Results start only after the scan pipeline has drained.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !sc_vld_reg)
        else $error("emit while scan data pending");

    // A result without a key is the single result of an empty report.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("empty report result not marked last");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for histogram_top_k_frequency: streams add and report items, predicts
// every ranked result in a behavioral copy of the histogram and compares each one.
// Depends on htkf_pkg and the RTL of the block.
module tb;
    import htkf_pkg::*;

    typedef struct {
        logic [KEY_W-1:0]  key;
        logic [FREQ_W-1:0] freq;
        logic              found;
        logic              last;
    } rank_result_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // [9:0] key, [15:10] zero
    logic [0:0]            s_tuser = '0;   // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // [9:0] top_key, [41:10] frequency, rest zero
    logic [0:0]            m_tuser;        // [0] found
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Behavioral copy of the block's state.
    bit [COUNT_BITS_DEF-1:0] key_counts [KEY_COUNT_DEF];
    bit [TOPCNT_W-1:0]       top_limit = TOP_COUNT_RST;
    rank_result_t            pending_ranks [$];
    rank_result_t            next_rank;

    int unsigned error_count = 0;
    int unsigned burst_left = 0;
    bit          hold_req = 1'b0;
    bit [KEY_W-1:0] hot_keys [24];

    histogram_top_k_frequency u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic count_key(input logic [KEY_W-1:0] key);
        if (key < KEY_COUNT_DEF && key_counts[key] != '1) begin
            key_counts[key]++;
        end
    endtask

    // Ranks the histogram the way the block does: ascending key scan, insertion
    // by strictly greater count, so equal counts keep the lower key in front.
    task automatic rank_histogram();
        bit [KEY_W-1:0]          keys [MAX_TOP_DEF];
        bit [COUNT_BITS_DEF-1:0] counts [MAX_TOP_DEF];
        int                      limit;
        int                      kept;
        int                      pos;
        rank_result_t            res;
        kept = 0;
        limit = (top_limit == 0) ? 1 : int'(top_limit);
        if (limit > MAX_TOP_DEF) limit = MAX_TOP_DEF;
        for (int k = 0; k < KEY_COUNT_DEF; k++) begin
            if (key_counts[k] == 0) continue;
            pos = kept;
            while (pos > 0 && counts[pos-1] < key_counts[k]) pos--;
            if (pos >= limit) continue;
            if (kept < limit) kept++;
            for (int r = kept - 1; r > pos; r--) begin
                keys[r] = keys[r-1];
                counts[r] = counts[r-1];
            end
            keys[pos] = k[KEY_W-1:0];
            counts[pos] = key_counts[k];
        end
        if (kept == 0) begin
            res = '{key: '0, freq: '0, found: 1'b0, last: 1'b1};
            pending_ranks.push_back(res);
        end else begin
            for (int r = 0; r < kept; r++) begin
                res.key = keys[r];
                res.freq = counts[r];
                res.found = 1'b1;
                res.last = (r == kept - 1);
                pending_ranks.push_back(res);
            end
        end
    endtask

    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(S_TDATA_W-KEY_W){1'b0}}, key};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_REPORT) rank_histogram();
        else count_key(key);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Waits until every expected result is received, then waits on so that an add, which leaves no result, can settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_ranks.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_top_count(input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_TOP_COUNT, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        top_limit = value[TOPCNT_W-1:0];
    endtask

    // Receiver: phases of random readiness, including full-rate phases, and a
    // long hold-off on request.
    always @(posedge aclk) begin
        static int hold_left = 0;
        static int phase_left = 0;
        static int ready_pct = 100;
        static bit hold_done = 1'b0;
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 1500;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    default: ready_pct = 30;
                endcase
                phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ranks.size() == 0) begin
                report_mismatch($sformatf("unexpected result key %0d", m_tdata[KEY_W-1:0]));
            end else begin
                next_rank = pending_ranks.pop_front();
                if (m_tdata[KEY_W-1:0] !== next_rank.key)
                    report_mismatch($sformatf("top_key %0d, expected %0d",
                                              m_tdata[KEY_W-1:0], next_rank.key));
                if (m_tdata[KEY_W +: FREQ_W] !== next_rank.freq)
                    report_mismatch($sformatf("frequency %0d, expected %0d",
                                              m_tdata[KEY_W +: FREQ_W], next_rank.freq));
                if (m_tuser[0] !== next_rank.found)
                    report_mismatch($sformatf("found %b, expected %b",
                                              m_tuser[0], next_rank.found));
                if (m_tlast !== next_rank.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              m_tlast, next_rank.last));
            end
        end
    end

    task automatic test_empty_report();
        send_item(CMD_REPORT, 10'h3FF);
    endtask

    // Extreme keys, alternating bit patterns and ties broken by the lower key.
    task automatic test_directed_ranking();
        send_item(CMD_ADD, 10'h3FF);
        send_item(CMD_ADD, 10'h000);
        send_item(CMD_ADD, 10'h2AA);
        send_item(CMD_ADD, 10'h155);
        send_item(CMD_ADD, 10'h2AA);
        send_item(CMD_ADD, 10'h3FF);
        send_item(CMD_ADD, 10'h3FF);
        send_item(CMD_ADD, 10'd7);
        send_item(CMD_ADD, 10'd3);
        send_item(CMD_REPORT, 10'h000);
    endtask

    task automatic test_register_limits();
        wait_idle();
        write_top_count(32'd0);
        send_item(CMD_REPORT, 10'h155);
        wait_idle();
        write_top_count(32'd31);
        for (int i = 0; i < 11; i++) send_item(CMD_ADD, 10'(100 + 37 * i));
        send_item(CMD_REPORT, 10'h2AA);
        wait_idle();
        write_top_count(32'd16);
        send_item(CMD_REPORT, 10'h000);
        wait_idle();
        write_top_count(32'hFFFF_FFF1);
        send_item(CMD_REPORT, 10'h3FF);
    endtask

    // Mostly adds on a skewed set of hot keys, with reports now and then and
    // a new report limit in each phase.
    task automatic test_random_traffic();
        logic [KEY_W-1:0] key;
        for (int i = 0; i < 24; i++) hot_keys[i] = KEY_W'($urandom_range(0, KEY_COUNT_DEF - 1));
        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: write_top_count(32'd1);
                1: write_top_count(32'd16);
                2: write_top_count(32'd31);
                default: write_top_count($urandom_range(0, 31));
            endcase
            for (int n = 0; n < 28; n++) begin
                if ($urandom_range(0, 99) < 70)
                    key = hot_keys[$urandom_range(0, $urandom_range(0, 23))];
                else
                    key = KEY_W'($urandom_range(0, KEY_COUNT_DEF - 1));
                if (n == 27 || $urandom_range(0, 99) < 7) send_item(CMD_REPORT, key);
                else send_item(CMD_ADD, key);
            end
        end
    endtask

    // The receiver holds off for longer than a scan, so the results back up
    // while the sender keeps offering adds behind the report.
    task automatic test_output_backpressure();
        wait_idle();
        write_top_count(32'd16);
        hold_req = 1'b1;
        send_item(CMD_REPORT, 10'h000);
        for (int i = 0; i < 10; i++) send_item(CMD_ADD, hot_keys[$urandom_range(0, 23)]);
        send_item(CMD_REPORT, 10'h3FF);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_report();
        test_directed_ranking();
        test_register_limits();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
src/htkf_pkg.sv
src/htkf_ram.sv
src/htkf_rank.sv
src/histogram_top_k_frequency.sv
tb/tb.sv
